[rtl/scbp_pkg.sv]
// Shared types, widths and size-class helpers for the size-class buffer pool.
package scbp_pkg;

  // Default configuration of the pool.
  localparam int POOL_DEPTH_DEF  = 1024;
  localparam int NUM_CLASSES_DEF = 8;
  localparam int HANDLE_BITS_DEF = 32;

  // Fixed widths of the request and result fields.
  localparam int SIZE_W   = 31;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 3;
  localparam int CLASS_W  = 4;
  localparam int LEVEL_W  = 11;
  localparam int TOTAL_W  = 48;

  // Byte size of the smallest class.
  localparam int BASE_CLASS_BYTES = 1024;

  // Request function codes.
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED      = 3'd0,
    ST_ALLOC_CLASS = 3'd1,
    ST_ALLOC_EXACT = 3'd2,
    ST_POOLED      = 3'd3,
    ST_FREE_DIRECT = 3'd4,
    ST_REJECTED    = 3'd5
  } status_t;

  // Byte size of class c: the base size doubled c times.
  function automatic logic [SIZE_W-1:0] class_bytes(input int unsigned c);
    return SIZE_W'(BASE_CLASS_BYTES) << c;
  endfunction

endpackage

[rtl/size_class_buffer_pool.sv]
// Size-class buffer pool: per-class LIFO stacks of free handles in one memory.
//
// Requests enter on the in_ channel (valid/stall): in_func selects allocate or
// release, in_size gives the byte size and in_handle the handle on release.
// One result per request leaves on the out_ channel (valid/stall), in order.
// A request is accepted at an edge with in_valid high and in_stall low.
// The accept cycle picks the size class, makes the decision and reads the
// stack memory; the execute step, once the result slot is free, updates the
// fill count, pushes the handle, updates the byte totals and loads the result
// register, and out_valid rises with it. in_stall is high during the execute
// step, so a new request is taken only after the last one has executed.
// The result register holds while out_stall is high; the block then accepts
// at most one more request and holds it until the result slot frees.
// Reset clears the fill counts, the byte totals and all handshake state. Stack
// entries are not cleared: a pop only reads an entry that an earlier push
// wrote, since the fill count starts at zero.
module size_class_buffer_pool #(
  parameter int POOL_DEPTH  = scbp_pkg::POOL_DEPTH_DEF,
  parameter int NUM_CLASSES = scbp_pkg::NUM_CLASSES_DEF,
  parameter int HANDLE_BITS = scbp_pkg::HANDLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [scbp_pkg::SIZE_W-1:0]   in_size,
  input  logic [scbp_pkg::HANDLE_W-1:0] in_handle,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [scbp_pkg::STATUS_W-1:0] out_status,
  output logic [scbp_pkg::HANDLE_W-1:0] out_handle,
  output logic [scbp_pkg::CLASS_W-1:0]  out_size_class,
  output logic [scbp_pkg::SIZE_W-1:0]   out_alloc_bytes,
  output logic [scbp_pkg::LEVEL_W-1:0]  out_pool_level,
  output logic [scbp_pkg::TOTAL_W-1:0]  out_outstanding_bytes,
  output logic [scbp_pkg::TOTAL_W-1:0]  out_freed_bytes,
  output logic [scbp_pkg::TOTAL_W-1:0]  out_peak_bytes
);

  // Derived widths.
  localparam int SizeW   = scbp_pkg::SIZE_W;
  localparam int HandleW = scbp_pkg::HANDLE_W;
  localparam int ClassW  = scbp_pkg::CLASS_W;
  localparam int LevelW  = scbp_pkg::LEVEL_W;
  localparam int TotalW  = scbp_pkg::TOTAL_W;
  localparam int StoreW  = (HANDLE_BITS < HandleW) ? HANDLE_BITS : HandleW;
  localparam int ClsW    = $clog2(NUM_CLASSES + 1);
  localparam int ClsIdxW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int LvlW    = $clog2(POOL_DEPTH + 1);
  localparam int Entries = NUM_CLASSES * POOL_DEPTH;
  localparam int AddrW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int SumW    = TotalW + 1;

  localparam logic [ClsW-1:0]   NoClass  = ClsW'(NUM_CLASSES);
  localparam logic [LvlW-1:0]   FullLvl  = LvlW'(POOL_DEPTH);
  localparam logic [TotalW-1:0] OutMax   = {1'b0, {(TotalW-1){1'b1}}};
  localparam logic [TotalW-1:0] OutMin   = {1'b1, {(TotalW-1){1'b0}}};
  localparam logic [TotalW-1:0] FreedMax = {TotalW{1'b1}};

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Control and request registers.
  state_t                   state_r;
  scbp_pkg::status_t        status_r;
  logic [ClsW-1:0]          cls_r;
  logic [SizeW-1:0]         bytes_r;
  logic [StoreW-1:0]        handle_r;
  logic [LvlW-1:0]          lvl_r;
  logic [SumW-1:0]          sum_out_r;
  logic [SumW-1:0]          sum_freed_r;

  // Pool state.
  logic [LvlW-1:0]          level_r [NUM_CLASSES];
  logic [TotalW-1:0]        out_total_r;
  logic [TotalW-1:0]        freed_total_r;
  logic [TotalW-1:0]        peak_r;
  logic [StoreW-1:0]        stack_mem [Entries];
  logic [StoreW-1:0]        rd_data_r;

  // Result register.
  logic                     out_valid_r;
  logic [scbp_pkg::STATUS_W-1:0] out_status_r;
  logic [HandleW-1:0]       out_handle_r;
  logic [ClassW-1:0]        out_class_r;
  logic [SizeW-1:0]         out_bytes_r;
  logic [LevelW-1:0]        out_level_r;

  // Accept-side decision signals.
  logic                     accept;
  logic                     exec_fire;
  logic [StoreW-1:0]        in_handle_m;
  logic [ClsW-1:0]          pick_cls;
  logic                     cls_ok;
  logic                     reject;
  logic [LvlW-1:0]          cur_lvl;
  logic [SizeW-1:0]         pick_bytes;
  scbp_pkg::status_t        status_nxt;
  logic [ClsW-1:0]          cls_nxt;
  logic [LvlW-1:0]          lvl_nxt;
  logic [SumW-1:0]          sum_out_nxt;
  logic [SumW-1:0]          sum_freed_nxt;
  logic                     rd_en;
  logic [AddrW-1:0]         rd_addr;

  // Execute-side signals.
  logic [AddrW-1:0]         exec_base;
  logic                     wr_en;
  logic [AddrW-1:0]         wr_addr;
  logic [TotalW-1:0]        out_sat;
  logic [TotalW-1:0]        freed_sat;
  logic [TotalW-1:0]        out_total_nxt;
  logic [TotalW-1:0]        freed_total_nxt;
  logic [TotalW-1:0]        peak_nxt;
  logic [LvlW-1:0]          new_lvl;
  logic [HandleW-1:0]       res_handle;
  logic [SizeW-1:0]         res_bytes;

  // Handshake: one request in flight; the execute step waits for a free result slot.
  assign exec_fire = (state_r == S_EXEC) && !(out_valid_r && out_stall);
  assign in_stall  = (state_r == S_EXEC);
  assign accept    = in_valid && !in_stall;

  // Smallest class that holds the size; NoClass when none does.
  always_comb begin
    pick_cls = NoClass;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (in_size <= scbp_pkg::class_bytes(c)) begin
        pick_cls = ClsW'(c);
      end
    end
  end

  assign in_handle_m = in_handle[StoreW-1:0];
  assign cls_ok      = (pick_cls != NoClass);
  assign reject      = (in_size == '0) ||
                       ((in_func == scbp_pkg::FUNC_RELEASE) && (in_handle_m == '0));
  assign cur_lvl     = cls_ok ? level_r[pick_cls[ClsIdxW-1:0]] : '0;
  assign pick_bytes  = cls_ok ? scbp_pkg::class_bytes(32'(pick_cls)) : in_size;

  // Decide the outcome of the request from the class and its fill count.
  always_comb begin
    cls_nxt = reject ? NoClass : pick_cls;
    lvl_nxt = reject ? '0 : cur_lvl;
    priority if (reject) begin
      status_nxt = scbp_pkg::ST_REJECTED;
    end else if (in_func == scbp_pkg::FUNC_ALLOC) begin
      if (cls_ok && (cur_lvl != '0)) begin
        status_nxt = scbp_pkg::ST_REUSED;
      end else if (cls_ok) begin
        status_nxt = scbp_pkg::ST_ALLOC_CLASS;
      end else begin
        status_nxt = scbp_pkg::ST_ALLOC_EXACT;
      end
    end else begin
      if (cls_ok && (cur_lvl < FullLvl)) begin
        status_nxt = scbp_pkg::ST_POOLED;
      end else begin
        status_nxt = scbp_pkg::ST_FREE_DIRECT;
      end
    end
  end

  // Running sums before saturation, prepared while the memory read is under way.
  assign sum_out_nxt = (in_func == scbp_pkg::FUNC_RELEASE)
                     ? {out_total_r[TotalW-1], out_total_r} - SumW'(pick_bytes)
                     : {out_total_r[TotalW-1], out_total_r} + SumW'(pick_bytes);
  assign sum_freed_nxt = {1'b0, freed_total_r} + SumW'(pick_bytes);

  // Pop address: top entry of the chosen class.
  assign rd_en   = accept && (status_nxt == scbp_pkg::ST_REUSED);
  assign rd_addr = AddrW'(AddrW'(pick_cls[ClsIdxW-1:0]) * AddrW'(POOL_DEPTH))
                 + AddrW'(cur_lvl - LvlW'(1));

  // Push address: first free entry of the held class.
  assign exec_base = AddrW'(AddrW'(cls_r[ClsIdxW-1:0]) * AddrW'(POOL_DEPTH));
  assign wr_en     = exec_fire && (status_r == scbp_pkg::ST_POOLED);
  assign wr_addr   = exec_base + AddrW'(lvl_r);

  // Saturation of the running totals.
  assign out_sat = (sum_out_r[SumW-1] != sum_out_r[SumW-2])
                 ? (sum_out_r[SumW-1] ? OutMin : OutMax)
                 : sum_out_r[TotalW-1:0];
  assign freed_sat = sum_freed_r[SumW-1] ? FreedMax : sum_freed_r[TotalW-1:0];

  // Results and state updates of the execute step.
  always_comb begin
    out_total_nxt   = out_total_r;
    freed_total_nxt = freed_total_r;
    peak_nxt        = peak_r;
    new_lvl         = lvl_r;
    res_handle      = '0;
    res_bytes       = bytes_r;
    unique case (status_r)
      scbp_pkg::ST_REUSED: begin
        new_lvl    = lvl_r - LvlW'(1);
        res_handle = HandleW'(rd_data_r);
        res_bytes  = '0;
      end
      scbp_pkg::ST_ALLOC_CLASS, scbp_pkg::ST_ALLOC_EXACT: begin
        out_total_nxt = out_sat;
        if (!out_sat[TotalW-1] && (out_sat != '0) && (out_sat > peak_r)) begin
          peak_nxt = out_sat;
        end
      end
      scbp_pkg::ST_POOLED: begin
        new_lvl         = lvl_r + LvlW'(1);
        out_total_nxt   = out_sat;
        freed_total_nxt = freed_sat;
      end
      scbp_pkg::ST_FREE_DIRECT: begin
        out_total_nxt   = out_sat;
        freed_total_nxt = freed_sat;
      end
      default: begin
        res_bytes = '0;
      end
    endcase
  end

  // Stack memory: one read and one write port, registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= handle_r;
    end
  end

  // Request registers, loaded at accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      cls_r       <= cls_nxt;
      bytes_r     <= pick_bytes;
      handle_r    <= in_handle_m;
      lvl_r       <= lvl_nxt;
      sum_out_r   <= sum_out_nxt;
      sum_freed_r <= sum_freed_nxt;
    end
  end

  // State machine, pool state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      out_total_r   <= '0;
      freed_total_r <= '0;
      peak_r        <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        level_r[c] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_valid_r && !out_stall) begin
            out_valid_r <= 1'b0;
          end
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            state_r       <= S_IDLE;
            out_valid_r   <= 1'b1;
            out_status_r  <= status_r;
            out_handle_r  <= res_handle;
            out_class_r   <= ClassW'(cls_r);
            out_bytes_r   <= res_bytes;
            out_level_r   <= LevelW'(new_lvl);
            out_total_r   <= out_total_nxt;
            freed_total_r <= freed_total_nxt;
            peak_r        <= peak_nxt;
            if (cls_r != NoClass) begin
              level_r[cls_r[ClsIdxW-1:0]] <= new_lvl;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The totals change only together with the result register, so they drive the ports.
  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_handle            = out_handle_r;
  assign out_size_class        = out_class_r;
  assign out_alloc_bytes       = out_bytes_r;
  assign out_pool_level        = out_level_r;
  assign out_outstanding_bytes = out_total_r;
  assign out_freed_bytes       = freed_total_r;
  assign out_peak_bytes        = peak_r;

  // A pop only happens on a class that holds at least one handle.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && (status_r == scbp_pkg::ST_REUSED)) |-> (level_r[cls_r[ClsIdxW-1:0]] != '0))
    else $error("pop from an empty class stack");

  // A push never goes past the stack depth.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (level_r[cls_r[ClsIdxW-1:0]] < FullLvl))
    else $error("push into a full class stack");

  // The peak always covers the outstanding total.
  a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
    $signed(out_total_r) <= $signed({1'b0, peak_r}))
    else $error("outstanding bytes above the recorded peak");

  // A new result appears only right after an execute step.
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result register loaded outside the execute step");

endmodule
